[rtl/core/mfrd_pkg.sv]
// Shared types, command codes and constant tables of the meter frame decoder.
`default_nettype none
package mfrd_pkg;

	localparam int VOLT_RANGES_DEF = 8;
	localparam int CURR_RANGES_DEF = 4;
	localparam int COUNT_MAX_DEF   = 255;
	localparam int QUEUE_DEPTH     = 2;
	localparam int CFG_REGS        = 3;

	localparam logic [7:0] CMD_NONE        = 8'h00;
	localparam logic [7:0] CMD_V_RANGE     = 8'h8A;
	localparam logic [7:0] CMD_V_ZERO      = 8'h9A;
	localparam logic [7:0] CMD_V_REF       = 8'h8D;
	localparam logic [7:0] CMD_V_SAMPLE    = 8'h9D;
	localparam logic [7:0] CMD_A_RANGE_2A  = 8'h8E;
	localparam logic [7:0] CMD_A_RANGE_600 = 8'h8F;
	localparam logic [7:0] CMD_A_ZERO      = 8'h9E;
	localparam logic [7:0] CMD_A_REF       = 8'hF8;
	localparam logic [7:0] CMD_A_SAMPLE    = 8'hD8;
	localparam logic [7:0] LETTER_A        = 8'h41;

	localparam logic [2:0] EV_VOLT_RANGE = 3'd0;
	localparam logic [2:0] EV_CURR_RANGE = 3'd1;
	localparam logic [2:0] EV_VOLT_VALUE = 3'd2;
	localparam logic [2:0] EV_CURR_VALUE = 3'd3;
	localparam logic [2:0] EV_UNKNOWN    = 3'd4;
	localparam logic [2:0] EV_BAD_RANGE  = 3'd5;

	localparam logic [1:0] POL_POS = 2'd0;
	localparam logic [1:0] POL_NEG = 2'd1;
	localparam logic [1:0] POL_AC  = 2'd2;

	localparam logic [1:0] LVL_VOLT_ZERO = 2'd0;
	localparam logic [1:0] LVL_VOLT_REF  = 2'd1;
	localparam logic [1:0] LVL_CURR_ZERO = 2'd2;
	localparam logic [1:0] LVL_CURR_REF  = 2'd3;

	localparam logic [1:0] CFG_VOLT_CAL_LOW  = 2'd0;
	localparam logic [1:0] CFG_VOLT_CAL_HIGH = 2'd1;
	localparam logic [1:0] CFG_CURR_CAL      = 2'd2;

	localparam logic [63:0] CAL_RESET = 64'd281479271743489000;
	localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
	localparam logic [19:0] MILLION   = 20'd1000000;

	typedef enum logic [1:0] {
		OP_EVENT = 2'd0,
		OP_LEVEL = 2'd1,
		OP_RMS   = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  kind;
		logic [2:0]  range_idx;
		logic        sw;
		logic [1:0]  pol;
		logic [31:0] value;
		logic [1:0]  lvl_sel;
		logic [39:0] sum;
		logic [7:0]  count;
		logic [15:0] zero;
		logic [15:0] ref_lvl;
	} job_t;

	typedef struct packed {
		logic        lvl_done;
		logic [15:0] volt_zero;
		logic [15:0] curr_zero;
	} back_stat_t;

	function automatic logic [16:0] volt_gain(input logic [2:0] r);
		case (r)
			3'd0:    volt_gain = 17'd530;
			3'd1:    volt_gain = 17'd1696;
			3'd2:    volt_gain = 17'd5300;
			3'd3:    volt_gain = 17'd10100;
			3'd4:    volt_gain = 17'd13250;
			3'd5:    volt_gain = 17'd32320;
			3'd6:    volt_gain = 17'd101000;
			default: volt_gain = 17'd1000;
		endcase
	endfunction

	function automatic logic [16:0] curr_gain(input logic [1:0] r);
		case (r)
			2'd0:    curr_gain = 17'd200;
			2'd1:    curr_gain = 17'd640;
			2'd2:    curr_gain = 17'd2000;
			default: curr_gain = 17'd5000;
		endcase
	endfunction

endpackage
`default_nettype wire

[rtl/core/mfrd_ifs.sv]
// Valid/ready channel interfaces for received bytes and decoded results.
`default_nettype none
interface mfrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface mfrd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [2:0]  range_index;
	logic        switch_position;
	logic [1:0]  polarity;
	logic [31:0] value;
	modport source (output valid, output event_kind, output range_index,
		output switch_position, output polarity, output value, input ready);
	modport sink (input valid, input event_kind, input range_index,
		input switch_position, input polarity, input value, output ready);
endinterface
`default_nettype wire

[rtl/core/mfrd_front.sv]
// Front end: parses bytes, tracks frames and ranges, accumulates samples, issues jobs.
`default_nettype none
module mfrd_front #(
	parameter int VOLT_RANGES = mfrd_pkg::VOLT_RANGES_DEF,
	parameter int CURR_RANGES = mfrd_pkg::CURR_RANGES_DEF,
	parameter int COUNT_MAX   = mfrd_pkg::COUNT_MAX_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	mfrd_in_if.sink              in_ch,
	input  wire                  q_full,
	input  mfrd_pkg::back_stat_t stat,
	output logic                 push,
	output mfrd_pkg::job_t       job
);

	logic [7:0]  active_q, pend_low_q;
	logic        pend_valid_q, lvl_busy_q;
	logic [39:0] sum_q;
	logic [7:0]  count_q, vneg_q, cneg_q;
	logic [3:0]  vrange_q;
	logic [2:0]  crange_q;
	logic        bsw_q;

	logic [7:0]  active_d, pend_low_d, count_d, vneg_d, cneg_d;
	logic        pend_valid_d, lvl_busy_d, bsw_d;
	logic [39:0] sum_d;
	logic [3:0]  vrange_d;
	logic [2:0]  crange_d;

	logic        acc;
	logic [7:0]  b;
	logic [9:0]  raw;
	logic [15:0] q16, zsel, dev;
	logic [31:0] sq;
	logic        is_sample, is_vs, sw_sel;
	logic [7:0]  rel;
	logic [2:0]  vr_use;
	logic [1:0]  cr_use;

	function automatic logic [1:0] pol_of(input logic [7:0] neg, input logic [7:0] cnt);
		if (neg <= 8'd2)
			pol_of = mfrd_pkg::POL_POS;
		else if (({2'b0, neg} + 10'd2) > {2'b0, cnt})
			pol_of = mfrd_pkg::POL_NEG;
		else
			pol_of = mfrd_pkg::POL_AC;
	endfunction

	assign in_ch.ready = !lvl_busy_q && !q_full;
	assign acc = in_ch.valid && in_ch.ready;
	assign b   = in_ch.data_byte;

	assign is_vs     = (active_q == mfrd_pkg::CMD_V_SAMPLE);
	assign is_sample = is_vs || (active_q == mfrd_pkg::CMD_A_SAMPLE);
	assign raw       = {b[3:0], pend_low_q[5:0]};
	assign q16       = {raw, 6'b0};
	assign zsel      = is_vs ? stat.volt_zero : stat.curr_zero;
	assign dev       = (q16 < zsel) ? (zsel - q16) : (q16 - zsel);
	assign sq        = dev * dev;
	assign rel       = b - mfrd_pkg::LETTER_A;
	assign sw_sel    = active_q[0];
	assign vr_use    = vrange_q[3] ? 3'd0 : vrange_q[2:0];
	assign cr_use    = crange_q[2] ? 2'd0 : crange_q[1:0];

	always_comb begin
		active_d     = active_q;
		pend_low_d   = pend_low_q;
		pend_valid_d = pend_valid_q;
		sum_d        = sum_q;
		count_d      = count_q;
		vneg_d       = vneg_q;
		cneg_d       = cneg_q;
		vrange_d     = vrange_q;
		crange_d     = crange_q;
		bsw_d        = bsw_q;
		lvl_busy_d   = lvl_busy_q && !stat.lvl_done;
		push         = 1'b0;
		job          = '0;
		job.op       = mfrd_pkg::OP_EVENT;
		job.sum      = sum_q;
		job.count    = count_q;
		if (acc) begin
			if (b[7]) begin
				case (active_q)
					mfrd_pkg::CMD_V_ZERO, mfrd_pkg::CMD_V_REF,
					mfrd_pkg::CMD_A_ZERO, mfrd_pkg::CMD_A_REF: begin
						job.op = mfrd_pkg::OP_LEVEL;
						case (active_q)
							mfrd_pkg::CMD_V_ZERO: job.lvl_sel = mfrd_pkg::LVL_VOLT_ZERO;
							mfrd_pkg::CMD_V_REF:  job.lvl_sel = mfrd_pkg::LVL_VOLT_REF;
							mfrd_pkg::CMD_A_ZERO: job.lvl_sel = mfrd_pkg::LVL_CURR_ZERO;
							default:              job.lvl_sel = mfrd_pkg::LVL_CURR_REF;
						endcase
						if (count_q != 8'd0) begin
							push       = 1'b1;
							lvl_busy_d = 1'b1;
						end
					end
					mfrd_pkg::CMD_V_SAMPLE: begin
						push          = 1'b1;
						job.op        = mfrd_pkg::OP_RMS;
						job.kind      = mfrd_pkg::EV_VOLT_VALUE;
						job.range_idx = vr_use;
						job.pol       = pol_of(vneg_q, count_q);
						job.zero      = stat.volt_zero;
						vneg_d        = 8'd0;
					end
					mfrd_pkg::CMD_A_SAMPLE: begin
						push          = 1'b1;
						job.op        = mfrd_pkg::OP_RMS;
						job.kind      = mfrd_pkg::EV_CURR_VALUE;
						job.range_idx = {1'b0, cr_use};
						job.sw        = bsw_q;
						job.pol       = pol_of(cneg_q, count_q);
						job.zero      = stat.curr_zero;
						cneg_d        = 8'd0;
					end
					mfrd_pkg::CMD_NONE, mfrd_pkg::CMD_V_RANGE,
					mfrd_pkg::CMD_A_RANGE_2A, mfrd_pkg::CMD_A_RANGE_600: begin
						push = 1'b0;
					end
					default: begin
						push      = 1'b1;
						job.kind  = mfrd_pkg::EV_UNKNOWN;
						job.value = {24'd0, active_q};
					end
				endcase
				active_d     = b;
				sum_d        = '0;
				count_d      = '0;
				pend_valid_d = 1'b0;
				pend_low_d   = '0;
			end else begin
				case (active_q)
					mfrd_pkg::CMD_V_RANGE: begin
						if (b < mfrd_pkg::LETTER_A ||
							b >= 8'(int'(mfrd_pkg::LETTER_A) + VOLT_RANGES)) begin
							push      = 1'b1;
							job.kind  = mfrd_pkg::EV_BAD_RANGE;
							job.value = {24'd0, b};
						end else if (vrange_q != {1'b0, rel[2:0]}) begin
							push          = 1'b1;
							vrange_d      = {1'b0, rel[2:0]};
							job.kind      = mfrd_pkg::EV_VOLT_RANGE;
							job.range_idx = rel[2:0];
						end
					end
					mfrd_pkg::CMD_A_RANGE_2A, mfrd_pkg::CMD_A_RANGE_600: begin
						if (b < mfrd_pkg::LETTER_A ||
							b >= 8'(int'(mfrd_pkg::LETTER_A) + CURR_RANGES)) begin
							push      = 1'b1;
							job.kind  = mfrd_pkg::EV_BAD_RANGE;
							job.sw    = sw_sel;
							job.value = {24'd0, b};
						end else if (crange_q != {1'b0, rel[1:0]} || bsw_q != sw_sel) begin
							push          = 1'b1;
							crange_d      = {1'b0, rel[1:0]};
							bsw_d         = sw_sel;
							job.kind      = mfrd_pkg::EV_CURR_RANGE;
							job.range_idx = {1'b0, rel[1:0]};
							job.sw        = sw_sel;
						end
					end
					mfrd_pkg::CMD_V_ZERO, mfrd_pkg::CMD_V_REF, mfrd_pkg::CMD_A_ZERO,
					mfrd_pkg::CMD_A_REF, mfrd_pkg::CMD_V_SAMPLE, mfrd_pkg::CMD_A_SAMPLE: begin
						if (!pend_valid_q) begin
							pend_low_d   = b;
							pend_valid_d = 1'b1;
						end else begin
							pend_valid_d = 1'b0;
							pend_low_d   = '0;
							if (count_q < 8'(COUNT_MAX)) begin
								count_d = count_q + 8'd1;
								if (is_sample) begin
									sum_d = sum_q + 40'(sq);
									if (q16 < zsel) begin
										if (is_vs)
											vneg_d = vneg_q + 8'd1;
										else
											cneg_d = cneg_q + 8'd1;
									end
								end else begin
									sum_d = sum_q + 40'(raw);
								end
							end
						end
					end
					default: begin
						push = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= mfrd_pkg::CMD_NONE;
			pend_low_q   <= '0;
			pend_valid_q <= 1'b0;
			lvl_busy_q   <= 1'b0;
			sum_q        <= '0;
			count_q      <= '0;
			vneg_q       <= '0;
			cneg_q       <= '0;
			vrange_q     <= 4'b1000;
			crange_q     <= 3'b100;
			bsw_q        <= 1'b0;
		end else begin
			active_q     <= active_d;
			pend_low_q   <= pend_low_d;
			pend_valid_q <= pend_valid_d;
			lvl_busy_q   <= lvl_busy_d;
			sum_q        <= sum_d;
			count_q      <= count_d;
			vneg_q       <= vneg_d;
			cneg_q       <= cneg_d;
			vrange_q     <= vrange_d;
			crange_q     <= crange_d;
			bsw_q        <= bsw_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/mfrd_queue.sv]
// Small job queue between the front end and the arithmetic back end.
`default_nettype none
module mfrd_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  mfrd_pkg::job_t  push_job,
	input  wire             pop,
	output mfrd_pkg::job_t  head,
	output logic            empty,
	output logic            full
);

	localparam int PW = (mfrd_pkg::QUEUE_DEPTH > 1) ? $clog2(mfrd_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(mfrd_pkg::QUEUE_DEPTH + 1);

	mfrd_pkg::job_t mem_q [mfrd_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(mfrd_pkg::QUEUE_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == PW'(mfrd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop && !empty)
				rd_q <= (rd_q == PW'(mfrd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && !empty);
		end
	end

endmodule
`default_nettype wire

[rtl/core/mfrd_back.sv]
// Back end: levels, calibration registers, iterative divide and root, result register.
`default_nettype none
module mfrd_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire  [1:0]           cfg_index,
	input  wire  [63:0]          cfg_data,
	input  mfrd_pkg::job_t       head,
	input  wire                  q_empty,
	output logic                 pop,
	output mfrd_pkg::back_stat_t stat,
	mfrd_out_if.source           out_ch
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MEAN = 4'd1;
	localparam logic [3:0] ST_SQRT = 4'd2;
	localparam logic [3:0] ST_MUL1 = 4'd3;
	localparam logic [3:0] ST_DIVT = 4'd4;
	localparam logic [3:0] ST_MUL2 = 4'd5;
	localparam logic [3:0] ST_DIVR = 4'd6;
	localparam logic [3:0] ST_LVL  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	localparam logic [19:0] MILLION_W = mfrd_pkg::MILLION;

	logic [3:0]  state_q;
	logic [63:0] vcal_lo_q, vcal_hi_q, ccal_q;
	logic [15:0] lvl_q [4];
	mfrd_pkg::job_t job_q;
	logic [15:0] diff_q, cal_q;
	logic [16:0] gain_q;
	logic [63:0] dvd_q, x_q, res_q, bit_q;
	logic [35:0] dvs_q, rem_q, d_q;
	logic [5:0]  cnt_q;
	logic [31:0] q1_q, val_q;
	logic [47:0] qc_q;
	logic        lvl_done_q;
	logic        ov_q;
	logic [2:0]  o_kind_q, o_range_q;
	logic        o_sw_q;
	logic [1:0]  o_pol_q;
	logic [31:0] o_val_q;

	logic [36:0] rem_sh;
	logic        ge;
	logic [35:0] rem_nx;
	logic [63:0] dvd_nx, trial;
	logic        last;
	logic [15:0] h_zero, h_ref, h_diff, h_cal;
	logic [16:0] h_gain;
	logic [2:0]  hr;
	logic [48:0] vsum;
	logic        out_free;
	logic [48:0] rg_mul;
	logic [51:0] rc_mul;

	assign rem_sh = {rem_q, dvd_q[63]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? 36'(rem_sh - {1'b0, dvs_q}) : rem_sh[35:0];
	assign dvd_nx = {dvd_q[62:0], ge};
	assign last   = (cnt_q == 6'd63);
	assign trial  = res_q + bit_q;
	assign vsum   = {1'b0, qc_q} + {1'b0, dvd_nx[47:0]};
	assign rg_mul = res_q[31:0] * gain_q;
	assign rc_mul = rem_q * cal_q;

	assign hr     = head.range_idx;
	assign h_zero = head.zero;
	assign h_ref  = (head.kind == mfrd_pkg::EV_VOLT_VALUE) ?
		lvl_q[mfrd_pkg::LVL_VOLT_REF] : lvl_q[mfrd_pkg::LVL_CURR_REF];
	assign h_diff = (h_ref > h_zero) ? (h_ref - h_zero) : (h_zero - h_ref);
	assign h_gain = (head.kind == mfrd_pkg::EV_VOLT_VALUE) ?
		mfrd_pkg::volt_gain(hr) : mfrd_pkg::curr_gain(hr[1:0]);

	always_comb begin
		if (head.kind == mfrd_pkg::EV_VOLT_VALUE)
			h_cal = hr[2] ? vcal_hi_q[{hr[1:0], 4'b0} +: 16] : vcal_lo_q[{hr[1:0], 4'b0} +: 16];
		else
			h_cal = ccal_q[{hr[1:0], 4'b0} +: 16];
	end

	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !ov_q || out_ch.ready;

	assign stat.lvl_done  = lvl_done_q;
	assign stat.volt_zero = lvl_q[mfrd_pkg::LVL_VOLT_ZERO];
	assign stat.curr_zero = lvl_q[mfrd_pkg::LVL_CURR_ZERO];

	assign out_ch.valid           = ov_q;
	assign out_ch.event_kind      = o_kind_q;
	assign out_ch.range_index     = o_range_q;
	assign out_ch.switch_position = o_sw_q;
	assign out_ch.polarity        = o_pol_q;
	assign out_ch.value           = o_val_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q  <= head;
				diff_q <= h_diff;
				cal_q  <= h_cal;
				gain_q <= h_gain;
				rem_q  <= '0;
				cnt_q  <= '0;
				res_q  <= '0;
				bit_q  <= 64'd1 << 62;
				x_q    <= '0;
				val_q  <= head.value;
				if (head.op == mfrd_pkg::OP_LEVEL) begin
					dvd_q <= 64'({head.sum, 6'b0});
					dvs_q <= 36'(head.count);
				end else begin
					dvd_q <= {head.sum, 24'b0};
					dvs_q <= 36'(head.count);
				end
				if (head.op == mfrd_pkg::OP_RMS) begin
					if (h_diff == 16'd0)
						val_q <= mfrd_pkg::SAT32;
					else if (h_cal == 16'd0)
						val_q <= '0;
				end
			end
			ST_MEAN, ST_LVL, ST_DIVT, ST_DIVR: begin
				dvd_q <= dvd_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + 6'd1;
				if (last) begin
					case (state_q)
						ST_MEAN: x_q <= dvd_nx;
						ST_DIVT: begin
							q1_q  <= dvd_nx[31:0];
							val_q <= mfrd_pkg::SAT32;
						end
						ST_DIVR: val_q <= (vsum > 49'(mfrd_pkg::SAT32)) ?
							mfrd_pkg::SAT32 : vsum[31:0];
						default: val_q <= val_q;
					endcase
				end
			end
			ST_SQRT: begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_MUL1: begin
				dvd_q <= {11'd0, rg_mul, 4'b0};
				dvs_q <= diff_q * MILLION_W;
				d_q   <= diff_q * MILLION_W;
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_MUL2: begin
				qc_q  <= q1_q * cal_q;
				dvd_q <= {12'd0, rc_mul};
				dvs_q <= d_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vcal_lo_q  <= mfrd_pkg::CAL_RESET;
			vcal_hi_q  <= mfrd_pkg::CAL_RESET;
			ccal_q     <= mfrd_pkg::CAL_RESET;
			lvl_q[0]   <= '0;
			lvl_q[1]   <= '0;
			lvl_q[2]   <= '0;
			lvl_q[3]   <= '0;
			lvl_done_q <= 1'b0;
			ov_q       <= 1'b0;
			o_kind_q   <= '0;
			o_range_q  <= '0;
			o_sw_q     <= 1'b0;
			o_pol_q    <= '0;
			o_val_q    <= '0;
		end else begin
			lvl_done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					mfrd_pkg::CFG_VOLT_CAL_LOW:  vcal_lo_q <= cfg_data;
					mfrd_pkg::CFG_VOLT_CAL_HIGH: vcal_hi_q <= cfg_data;
					mfrd_pkg::CFG_CURR_CAL:      ccal_q <= cfg_data;
					default:                     ccal_q <= ccal_q;
				endcase
			end
			if (out_ch.ready)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						case (head.op)
							mfrd_pkg::OP_LEVEL: state_q <= ST_LVL;
							mfrd_pkg::OP_RMS: begin
								if (h_diff == 16'd0 || h_cal == 16'd0)
									state_q <= ST_OUT;
								else if (head.count == 8'd0)
									state_q <= ST_SQRT;
								else
									state_q <= ST_MEAN;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MEAN: if (last) state_q <= ST_SQRT;
				// leave after the step with the lowest root bit
				ST_SQRT: if (bit_q == 64'd1) state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_DIVT;
				ST_DIVT: if (last) state_q <= (dvd_nx[63:32] != 32'd0) ? ST_OUT : ST_MUL2;
				ST_MUL2: state_q <= ST_DIVR;
				ST_DIVR: if (last) state_q <= ST_OUT;
				ST_LVL: begin
					if (last) begin
						lvl_q[job_q.lvl_sel] <= dvd_nx[15:0];
						lvl_done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						ov_q      <= 1'b1;
						o_kind_q  <= job_q.kind;
						o_range_q <= job_q.range_idx;
						o_sw_q    <= job_q.sw;
						o_pol_q   <= job_q.pol;
						o_val_q   <= val_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/meter_frame_rms_decoder_core.sv]
// Meter frame decoder with RMS evaluation: top level.
// Usage:
//   in_ch carries one received byte per transaction; a byte with bit 7 set is a
//   command that closes the open frame. out_ch carries decoded events: range
//   changes, bad range letters, unknown commands and RMS values in Q16.16.
//   cfg_we/cfg_index/cfg_data write the three calibration registers; write them
//   only while no byte is in flight.
// Timing:
//   Range and command events pass through the job queue, the back end's job
//   register and the result register. An RMS value runs a 64-step mean divide,
//   a 32-step square root and two 64-step divides on one shared shift-subtract
//   divider. Closing a nonempty zero or reference frame runs a 64-step divide,
//   and the input is held off until the new level is stored. Other bytes are
//   taken one a cycle while the two-entry job queue has room.
// Reset clears all frame state, sets ranges to unknown and calibration to 1000.
// When the receiver stalls, the result register holds, the queue fills and
//   in_ch.ready drops.
`default_nettype none
module meter_frame_rms_decoder_core #(
	parameter int VOLT_RANGES = mfrd_pkg::VOLT_RANGES_DEF,
	parameter int CURR_RANGES = mfrd_pkg::CURR_RANGES_DEF,
	parameter int COUNT_MAX   = mfrd_pkg::COUNT_MAX_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	mfrd_in_if.sink    in_ch,
	mfrd_out_if.source out_ch,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [63:0] cfg_data
);

	logic                 push, pop, q_empty, q_full;
	mfrd_pkg::job_t       push_job, head;
	mfrd_pkg::back_stat_t stat;

	mfrd_front #(
		.VOLT_RANGES(VOLT_RANGES),
		.CURR_RANGES(CURR_RANGES),
		.COUNT_MAX(COUNT_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.q_full(q_full),
		.stat(stat),
		.push(push),
		.job(push_job)
	);

	mfrd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.empty(q_empty),
		.full(q_full)
	);

	mfrd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.head(head),
		.q_empty(q_empty),
		.pop(pop),
		.stat(stat),
		.out_ch(out_ch)
	);

endmodule
`default_nettype wire
